// ----- hw/rtl/static_prefix_code_bit_packer_top_defines.svh -----
// assertion macros for the prefix code packer
`ifndef STATIC_PREFIX_CODE_BIT_PACKER_TOP_DEFINES_SVH
`define STATIC_PREFIX_CODE_BIT_PACKER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define SPCBP_ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define SPCBP_ASSERT_IMPLIES(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define SPCBP_ASSERT_ALWAYS(name, expr, msg)
`define SPCBP_ASSERT_IMPLIES(name, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/spcbp_pkg.sv -----
package spcbp_pkg;

	// field and datapath widths
	localparam int SymW   = 8;
	localparam int ByteW  = 8;
	localparam int CodeW  = 6;
	localparam int LenW   = 3;
	localparam int CountW = 3;
	localparam int TotalW = CountW + 1;
	localparam int AccW   = 2 * ByteW;

	// queue between classifier and packer
	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	// input action codes
	localparam logic ACTION_ENCODE = 1'b0;
	localparam logic ACTION_FLUSH  = 1'b1;

	// result status codes
	localparam logic STATUS_DATA    = 1'b0;
	localparam logic STATUS_UNKNOWN = 1'b1;

	// character codes of the known symbols
	localparam logic [SymW-1:0] CHAR_0       = 8'h30;
	localparam logic [SymW-1:0] CHAR_1       = 8'h31;
	localparam logic [SymW-1:0] CHAR_2       = 8'h32;
	localparam logic [SymW-1:0] CHAR_3       = 8'h33;
	localparam logic [SymW-1:0] CHAR_4       = 8'h34;
	localparam logic [SymW-1:0] CHAR_5       = 8'h35;
	localparam logic [SymW-1:0] CHAR_6       = 8'h36;
	localparam logic [SymW-1:0] CHAR_7       = 8'h37;
	localparam logic [SymW-1:0] CHAR_8       = 8'h38;
	localparam logic [SymW-1:0] CHAR_9       = 8'h39;
	localparam logic [SymW-1:0] CHAR_DOT     = 8'h2E;
	localparam logic [SymW-1:0] CHAR_E       = 8'h65;
	localparam logic [SymW-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [SymW-1:0] CHAR_MINUS   = 8'h2D;
	localparam logic [SymW-1:0] CHAR_PLUS    = 8'h2B;
	localparam logic [SymW-1:0] CHAR_NEWLINE = 8'h0A;

	// classified item kinds
	typedef enum logic [1:0] {
		KIND_CODE    = 2'd0,
		KIND_UNKNOWN = 2'd1,
		KIND_FLUSH   = 2'd2
	} kind_t;

	// one classified item: code bits lsb first and code length
	typedef struct packed {
		kind_t             kind;
		logic [CodeW-1:0]  bits;
		logic [LenW-1:0]   len;
	} item_t;

	// queue status seen by the classifier
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// map an incoming item onto its code
	function automatic item_t classify(logic action, logic [SymW-1:0] symbol);
		item_t it;
		it.kind = KIND_CODE;
		it.bits = '0;
		it.len  = '0;
		if (action == ACTION_FLUSH) begin
			it.kind = KIND_FLUSH;
		end else begin
			unique case (symbol)
				CHAR_0:       begin it.bits = 6'd2;  it.len = 3'd2; end
				CHAR_1:       begin it.bits = 6'd4;  it.len = 3'd3; end
				CHAR_2:       begin it.bits = 6'd3;  it.len = 3'd4; end
				CHAR_3:       begin it.bits = 6'd13; it.len = 3'd4; end
				CHAR_4:       begin it.bits = 6'd8;  it.len = 3'd4; end
				CHAR_5:       begin it.bits = 6'd11; it.len = 3'd4; end
				CHAR_6:       begin it.bits = 6'd15; it.len = 3'd5; end
				CHAR_7:       begin it.bits = 6'd5;  it.len = 3'd4; end
				CHAR_8:       begin it.bits = 6'd7;  it.len = 3'd5; end
				CHAR_9:       begin it.bits = 6'd1;  it.len = 3'd4; end
				CHAR_DOT:     begin it.bits = 6'd31; it.len = 3'd5; end
				CHAR_E:       begin it.bits = 6'd0;  it.len = 3'd4; end
				CHAR_SPACE:   begin it.bits = 6'd23; it.len = 3'd5; end
				CHAR_MINUS:   begin it.bits = 6'd25; it.len = 3'd5; end
				CHAR_PLUS:    begin it.bits = 6'd41; it.len = 3'd6; end
				CHAR_NEWLINE: begin it.bits = 6'd9;  it.len = 3'd6; end
				default:      it.kind = KIND_UNKNOWN;
			endcase
		end
		return it;
	endfunction

endpackage

// ----- hw/rtl/spcbp_in_if.sv -----
interface spcbp_in_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [spcbp_pkg::SymW-1:0]    symbol;

	modport source (output valid, output action, output symbol, input ready);
	modport sink   (input valid, input action, input symbol, output ready);
endinterface

// ----- hw/rtl/spcbp_out_if.sv -----
interface spcbp_out_if;
	logic                          valid;
	logic                          ready;
	logic [spcbp_pkg::ByteW-1:0]   out_byte;
	logic                          status;
	logic                          last;

	modport source (output valid, output out_byte, output status, output last, input ready);
	modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ----- hw/rtl/spcbp_front.sv -----
module spcbp_front (
	spcbp_in_if.sink                symbols,
	input  spcbp_pkg::q_stat_t      q_stat,
	output logic                    push,
	output spcbp_pkg::item_t        item
);

	// accept whenever the queue has room
	assign symbols.ready = !q_stat.full;
	assign push          = symbols.valid && symbols.ready;

	// code lookup
	assign item = spcbp_pkg::classify(symbols.action, symbols.symbol);

endmodule

// ----- hw/rtl/spcbp_queue.sv -----
module spcbp_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  spcbp_pkg::item_t        push_item,
	input  logic                    pop,
	output spcbp_pkg::item_t        head_item,
	output spcbp_pkg::q_stat_t      q_stat
);

	spcbp_pkg::item_t                     entries_q [spcbp_pkg::QueueDepth];
	logic [spcbp_pkg::QueuePtrW-1:0]      wr_ptr_q;
	logic [spcbp_pkg::QueuePtrW-1:0]      rd_ptr_q;
	logic [spcbp_pkg::QueueCntW-1:0]      count_q;

	localparam logic [spcbp_pkg::QueuePtrW-1:0] LastPtr =
		spcbp_pkg::QueuePtrW'(spcbp_pkg::QueueDepth - 1);
	localparam logic [spcbp_pkg::QueueCntW-1:0] FullCnt =
		spcbp_pkg::QueueCntW'(spcbp_pkg::QueueDepth);

	// status flags
	assign q_stat.full  = (count_q == FullCnt);
	assign q_stat.empty = (count_q == '0);
	assign head_item    = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/spcbp_back.sv -----
module spcbp_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  spcbp_pkg::item_t        head_item,
	output logic                    pop,
	spcbp_out_if.source             packed_bytes
);

	logic [spcbp_pkg::ByteW-1:0]    pend_bits_q;
	logic [spcbp_pkg::CountW-1:0]   pend_count_q;
	logic                           out_valid_q;
	logic [spcbp_pkg::ByteW-1:0]    out_byte_q;
	logic                           out_status_q;
	logic                           out_last_q;

	logic [spcbp_pkg::AccW-1:0]     acc;
	logic [spcbp_pkg::TotalW-1:0]   total;
	logic                           emit;
	logic [spcbp_pkg::ByteW-1:0]    byte_d;
	logic                           status_d;
	logic                           last_d;

	// take the next item when the output register is free or being drained
	assign pop = head_valid && (!out_valid_q || packed_bytes.ready);

	// shift the code in above the pending bits
	assign acc   = spcbp_pkg::AccW'(pend_bits_q)
		| (spcbp_pkg::AccW'(head_item.bits) << pend_count_q);
	assign total = spcbp_pkg::TotalW'(pend_count_q) + spcbp_pkg::TotalW'(head_item.len);

	// result that the head item yields, if any
	always_comb begin
		emit     = 1'b0;
		byte_d   = acc[spcbp_pkg::ByteW-1:0];
		status_d = spcbp_pkg::STATUS_DATA;
		last_d   = 1'b0;
		unique case (head_item.kind)
			spcbp_pkg::KIND_FLUSH: begin
				emit   = (pend_count_q != '0);
				byte_d = pend_bits_q;
				last_d = 1'b1;
			end
			spcbp_pkg::KIND_UNKNOWN: begin
				emit     = 1'b1;
				byte_d   = '0;
				status_d = spcbp_pkg::STATUS_UNKNOWN;
			end
			spcbp_pkg::KIND_CODE: begin
				emit = total[spcbp_pkg::CountW];
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// packer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q  <= '0;
			pend_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= emit;
				unique case (head_item.kind)
					spcbp_pkg::KIND_FLUSH: begin
						pend_bits_q  <= '0;
						pend_count_q <= '0;
					end
					spcbp_pkg::KIND_UNKNOWN: begin
						pend_count_q <= pend_count_q;
					end
					spcbp_pkg::KIND_CODE: begin
						if (total[spcbp_pkg::CountW]) begin
							pend_bits_q <= acc[spcbp_pkg::AccW-1:spcbp_pkg::ByteW];
						end else begin
							pend_bits_q <= acc[spcbp_pkg::ByteW-1:0];
						end
						pend_count_q <= total[spcbp_pkg::CountW-1:0];
					end
					default: begin
						pend_count_q <= pend_count_q;
					end
				endcase
			end else if (packed_bytes.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q   <= byte_d;
			out_status_q <= status_d;
			out_last_q   <= last_d;
		end
	end

	assign packed_bytes.valid    = out_valid_q;
	assign packed_bytes.out_byte = out_byte_q;
	assign packed_bytes.status   = out_status_q;
	assign packed_bytes.last     = out_last_q;

endmodule

// ----- hw/rtl/static_prefix_code_bit_packer_top.sv -----
// an accepted item is held in the queue, and its result, if any, is registered in the output register
// throughput: one item per cycle while the output is taken, set by the combinational code lookup and shift-in
// a two-entry queue separates the classifier from the packer, so either side may stall
// reset (arst_n low, asynchronous) clears the queue pointers and count, the pending bits and the output valid flag
`include "static_prefix_code_bit_packer_top_defines.svh"

module static_prefix_code_bit_packer_top (
	input  logic          clk,
	input  logic          arst_n,
	spcbp_in_if.sink      symbols,
	spcbp_out_if.source   packed_bytes
);

	logic                   push;
	logic                   pop;
	spcbp_pkg::item_t       push_item;
	spcbp_pkg::item_t       head_item;
	spcbp_pkg::q_stat_t     q_stat;

	// classify incoming items
	spcbp_front u_front (
		.symbols   (symbols),
		.q_stat    (q_stat),
		.push      (push),
		.item      (push_item)
	);

	// decoupling queue
	spcbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_stat    (q_stat)
	);

	// bit packer and output register
	spcbp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!q_stat.empty),
		.head_item    (head_item),
		.pop          (pop),
		.packed_bytes (packed_bytes)
	);

	// checks
	`SPCBP_ASSERT_IMPLIES(a_no_push_when_full, q_stat.full, !push, "push into full queue")
	`SPCBP_ASSERT_IMPLIES(a_no_pop_when_empty, pop, !q_stat.empty, "pop from empty queue")
	`SPCBP_ASSERT_IMPLIES(a_unknown_result_clean, packed_bytes.valid && packed_bytes.status,
		(packed_bytes.out_byte == '0) && !packed_bytes.last, "unknown result carries data")

endmodule
